// ----- src/bevg_pkg.sv -----
`timescale 1ns / 1ps

package bevg_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 3;
  localparam int unsigned MAX_BUTTONS     = 8;

  // op codes of an input item
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_EDGE    = 2'd1;
  localparam logic [1:0] OP_RETRIG  = 2'd2;

  // event kinds
  localparam logic [1:0] EV_PUSH    = 2'd0;
  localparam logic [1:0] EV_LONG    = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LONG_KEYS   = 2'd0;
  localparam logic [1:0] CFG_ANTI_BOUNCE = 2'd1;
  localparam logic [1:0] CFG_LONG_TICKS  = 2'd2;
  localparam logic [1:0] CFG_REPEAT      = 2'd3;

  localparam logic [7:0] GUARD_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] button;
    logic       last;
  } evt_t;

  // events produced by one item, at most two
  typedef struct packed {
    logic [1:0] cnt;
    evt_t       ev0;
    evt_t       ev1;
  } result_t;

  // index of the lowest set bit, 0 for an empty mask
  function automatic logic [2:0] lowest_idx(input logic [MAX_BUTTONS-1:0] m);
    logic [2:0] idx;
    idx = '0;
    for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- src/bevg_engine.sv -----
`timescale 1ns / 1ps

module bevg_engine #(
  parameter int unsigned NUM_BUTTONS = bevg_pkg::NUM_BUTTONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              fire_i,
  input  logic [1:0]        op_i,
  input  logic [2:0]        levels_i,
  input  logic [2:0]        keys_i,
  input  logic [7:0]        timeout_i,
  output bevg_pkg::result_t res_o
);
  import bevg_pkg::*;

  localparam int unsigned NB = NUM_BUTTONS;

  logic [NB-1:0] lpk_q;
  logic [7:0]    ab_q, lpt_q, rt_q;

  logic [7:0]    gc_q, gc_d;
  logic [NB-1:0] pend_q, pend_d;
  logic [NB-1:0] armed_q, armed_d;
  logic [NB-1:0] rep_q, rep_d;
  logic [7:0]    reload_q, reload_d;

  logic [NB-1:0] lev, keys;
  logic [NB-1:0] early, lmask, rmask, released, rel_free, rel_pend, done;
  logic [NB-1:0] oh_early, oh_long;
  logic [2:0]    idx_early, idx_long, idx_rep;
  logic [7:0]    g;
  logic          rep_hit, rel_hit;
  logic [1:0]    rel_kind;
  logic [2:0]    rel_idx;

  assign lev      = NB'(levels_i);
  assign keys     = NB'(keys_i);
  assign early    = pend_q & ~lpk_q;
  assign lmask    = pend_q & lpk_q;
  assign rmask    = ~armed_q & rep_q;
  assign released = lev & ~armed_q;
  assign rel_free = released & ~pend_q;
  assign rel_pend = released & pend_q;
  assign oh_early = early & (~early + NB'(1));
  assign oh_long  = lmask & (~lmask + NB'(1));

  assign idx_early = lowest_idx(MAX_BUTTONS'(early));
  assign idx_long  = lowest_idx(MAX_BUTTONS'(lmask));
  assign idx_rep   = lowest_idx(MAX_BUTTONS'(rmask));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpk_q <= '0;
      ab_q  <= 8'd2;
      lpt_q <= 8'd64;
      rt_q  <= 8'd34;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LONG_KEYS:   lpk_q <= NB'(cfg_data_i[2:0]);
        CFG_ANTI_BOUNCE: ab_q  <= cfg_data_i;
        CFG_LONG_TICKS:  lpt_q <= cfg_data_i;
        CFG_REPEAT:      rt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    gc_d     = gc_q;
    pend_d   = pend_q;
    armed_d  = armed_q;
    rep_d    = rep_q;
    reload_d = reload_q;
    g        = gc_q;
    done     = '0;
    rep_hit  = 1'b0;
    rel_hit  = 1'b0;
    rel_kind = EV_RELEASE;
    rel_idx  = '0;
    res_o    = '0;
    case (op_i)
      OP_TICK: begin
        if (gc_q != 8'd0) begin
          if (gc_q == 8'd1 && early != '0) begin
            pend_d     = pend_q & ~oh_early;
            res_o.cnt  = 2'd1;
            res_o.ev0  = '{kind: EV_PUSH, button: idx_early[1:0], last: 1'b1};
          end else if (gc_q < ab_q) begin
            gc_d = gc_q + 8'd1;
          end else if (gc_q == lpt_q && lmask != '0) begin
            pend_d     = pend_q & ~oh_long;
            res_o.cnt  = 2'd1;
            res_o.ev0  = '{kind: EV_LONG, button: idx_long[1:0], last: 1'b1};
          end else begin
            if (gc_q == rt_q && rmask != '0) begin
              g       = reload_q;
              rep_d   = '0;
              rep_hit = 1'b1;
            end
            if (g != GUARD_MAX) begin
              g = g + 8'd1;
            end
            // a plain release wins over a push deferred to release
            if (rel_free != '0) begin
              done    = rel_free & (~rel_free + NB'(1));
              rel_hit = 1'b1;
              rel_idx = lowest_idx(MAX_BUTTONS'(rel_free));
            end else if (rel_pend != '0) begin
              done     = rel_pend & (~rel_pend + NB'(1));
              pend_d   = pend_q & ~done;
              rel_hit  = 1'b1;
              rel_kind = EV_PUSH;
              rel_idx  = lowest_idx(MAX_BUTTONS'(rel_pend));
            end
            armed_d = armed_q | done;
            if (&armed_d) begin
              g = '0;
            end
            gc_d = g;
            if (rep_hit) begin
              res_o.ev0 = '{kind: EV_PUSH, button: idx_rep[1:0], last: ~rel_hit};
              if (rel_hit) begin
                res_o.ev1 = '{kind: rel_kind, button: rel_idx[1:0], last: 1'b1};
                res_o.cnt = 2'd2;
              end else begin
                res_o.cnt = 2'd1;
              end
            end else if (rel_hit) begin
              res_o.ev0 = '{kind: rel_kind, button: rel_idx[1:0], last: 1'b1};
              res_o.cnt = 2'd1;
            end
          end
        end
      end
      OP_EDGE: begin
        pend_d  = pend_q | (armed_q & ~lev);
        armed_d = armed_q & lev;
        gc_d    = 8'd1;
      end
      OP_RETRIG: begin
        rep_d    = keys;
        reload_d = rt_q - timeout_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q     <= '0;
      pend_q   <= '0;
      armed_q  <= '1;
      rep_q    <= '0;
      reload_q <= '0;
    end else if (fire_i) begin
      gc_q     <= gc_d;
      pend_q   <= pend_d;
      armed_q  <= armed_d;
      rep_q    <= rep_d;
      reload_q <= reload_d;
    end
  end

endmodule

// ----- src/bevg_out_buf.sv -----
`timescale 1ns / 1ps

module bevg_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bevg_pkg::result_t res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bevg_pkg::evt_t    ev_o
);
  import bevg_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  evt_t       e0_q, e0_d, e1_q, e1_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  // empty, or its single item leaves this cycle
  assign can_load_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign ev_o        = e0_q;

  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    if (load_i) begin
      cnt_d = res_i.cnt;
      e0_d  = res_i.ev0;
      e1_d  = res_i.ev1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      e0_d  = e1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

// ----- src/button_event_generator_core.sv -----
`timescale 1ns / 1ps

// Button event generator: debounce, long press and repeat for a row of buttons.
// Input channel (in_valid_i/in_ready_o) carries one item: a tick, a falling-edge
// notice with the raw pin levels, or a retrigger request with keys and timeout.
// Output channel (out_valid_o/out_ready_i) carries events: kind, button, last.
// An item that causes events has last set on its final one.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i;
// write only while the block is idle.
// Path: an item is taken into the input register, processed by the engine once
// the result buffer can load, and its first event is shown from that buffer.
// Throughput: one item per cycle while each gives at most one event and the
// receiver is ready; a tick with a repeat push and a release fills the buffer,
// so the next item waits until its second event leaves the single output port.
// Reset: all buttons armed, guard timer idle, configuration at defaults.
// When the receiver stalls, events wait in the two-entry result buffer, the
// next item waits in the input register, and in_ready_o then drops.
module button_event_generator_core #(
  parameter int unsigned NUM_BUTTONS = bevg_pkg::NUM_BUTTONS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [2:0] button_levels_i,
  input  logic [2:0] keys_i,
  input  logic [7:0] timeout_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_kind_o,
  output logic [1:0] button_o,
  output logic       last_o
);
  import bevg_pkg::*;

  logic       in_vld_q;
  logic [1:0] op_q;
  logic [2:0] lev_q, keys_q;
  logic [7:0] tmo_q;
  logic       can_load, fire;
  result_t    res;
  evt_t       ev;

  assign fire       = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_i;
      lev_q  <= button_levels_i;
      keys_q <= keys_i;
      tmo_q  <= timeout_i;
    end
  end

  bevg_engine #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .fire_i    (fire),
    .op_i      (op_q),
    .levels_i  (lev_q),
    .keys_i    (keys_q),
    .timeout_i (tmo_q),
    .res_o     (res)
  );

  bevg_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .res_i      (res),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ev_o       (ev)
  );

  assign event_kind_o = ev.kind;
  assign button_o     = ev.button;
  assign last_o       = ev.last;

endmodule

// ----- src/bevg_checker.sv -----
`timescale 1ns / 1ps

module bevg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] event_kind_o,
  input logic [1:0] button_o,
  input logic       last_o
);
  import bevg_pkg::*;

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(event_kind_o) && $stable(button_o) && $stable(last_o))
    else $error("stalled event changed");

  // the second event of a tick follows straight after the first
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("second event of a pair missing");

  // only a repeat push can lead a pair
  a_lead_is_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> event_kind_o == EV_PUSH)
    else $error("non-push event leads a pair");

  a_long_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_LONG |-> last_o)
    else $error("long press not alone");

endmodule

bind button_event_generator_core bevg_checker u_bevg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .event_kind_o(event_kind_o),
  .button_o    (button_o),
  .last_o      (last_o)
);
